@@ design/two_half_sort_and_merge_macros.svh @@
// Assertion helpers shared by the block's modules.
`ifndef TWO_HALF_SORT_AND_MERGE_MACROS_SVH
`define TWO_HALF_SORT_AND_MERGE_MACROS_SVH

// Check on every clock edge outside reset.
`define TSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define TSM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/tsm_pkg.sv @@
package tsm_pkg;

  localparam int SET_SIZE  = 16;
  localparam int HALF_SIZE = SET_SIZE / 2;
  localparam int ADDR_W    = $clog2(SET_SIZE);
  localparam int CNT_W     = $clog2(SET_SIZE + 1);
  localparam int DATA_W    = 32;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [CNT_W-1:0] HALF_CNT = CNT_W'(HALF_SIZE);
  localparam logic [CNT_W-1:0] SET_CNT  = CNT_W'(SET_SIZE);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SET_SIZE - 1);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [ADDR_W-1:0] idx;
    logic              last;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } q_head_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_OUTER,
    ST_CUR,
    ST_SCAN,
    ST_SWAP1,
    ST_SWAP2,
    ST_MFETCH,
    ST_MEMIT
  } tsm_state_t;

endpackage

@@ design/tsm_ram.sv @@
module tsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/tsm_front.sv @@
module tsm_front
  import tsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [DATA_W-1:0] in_value,
  input  logic              q_full,
  output logic              q_push,
  output req_t              q_req
);
`include "two_half_sort_and_merge_macros.svh"

  logic [CNT_W-1:0] load_count_r;
  logic [CNT_W-1:0] load_count_nxt;
  logic             is_last;

  assign full    = q_full;
  assign q_push  = push && !q_full;
  assign is_last = (load_count_r == LAST_CNT);

  always_comb begin
    q_req.value = in_value;
    q_req.idx   = load_count_r[ADDR_W-1:0];
    q_req.last  = is_last;
    load_count_nxt = load_count_r;
    if (q_push) begin
      load_count_nxt = is_last ? '0 : load_count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
    end else begin
      load_count_r <= load_count_nxt;
    end
  end

  `TSM_ASSERT(a_count_range, load_count_r < SET_CNT, "load count out of range")
  `TSM_ASSERT(a_count_wrap, q_push && is_last |=> load_count_r == '0,
              "load count did not wrap after last request")

endmodule

@@ design/tsm_queue.sv @@
module tsm_queue
  import tsm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_push,
  input  req_t    q_req,
  output logic    q_full,
  input  logic    q_pop,
  output q_head_t q_head
);
`include "two_half_sort_and_merge_macros.svh"

  req_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;

  assign q_full       = (count_r == QCNT_W'(QDEPTH));
  assign do_push      = q_push && !q_full;
  assign do_pop       = q_pop && (count_r != '0);
  assign q_head.valid = (count_r != '0);
  assign q_head.req   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= q_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `TSM_ASSERT(a_pop_nonempty, q_pop |-> count_r != '0, "queue popped while empty")
  `TSM_ASSERT(a_count_max, count_r <= QCNT_W'(QDEPTH), "queue count overflow")

endmodule

@@ design/tsm_back.sv @@
module tsm_back
  import tsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  q_head_t           q_head,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [DATA_W-1:0] out_sorted_value,
  output logic              out_final_res
);
`include "two_half_sort_and_merge_macros.svh"

  tsm_state_t        state_r, state_nxt;
  logic              half_r, half_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [CNT_W-1:0]  pick_r, pick_nxt;
  logic [CNT_W-1:0]  ridx_r, ridx_nxt;
  logic              rv_r, rv_nxt;
  logic [DATA_W-1:0] best_r, best_nxt;
  logic [DATA_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0]  a_r, a_nxt;
  logic [CNT_W-1:0]  b_r, b_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_final_r, out_final_nxt;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;
  logic              re0, re1;
  logic [ADDR_W-1:0] raddr0, raddr1;
  logic [DATA_W-1:0] rdata0, rdata1;

  logic [CNT_W-1:0]  hi;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  i_inc;
  logic              take_first;
  logic              slot_free;
  logic              emit;

  tsm_ram #(.WIDTH(DATA_W), .DEPTH(SET_SIZE)) u_ram0 (
    .clk, .we, .waddr, .wdata, .re(re0), .raddr(raddr0), .rdata(rdata0)
  );

  tsm_ram #(.WIDTH(DATA_W), .DEPTH(SET_SIZE)) u_ram1 (
    .clk, .we, .waddr, .wdata, .re(re1), .raddr(raddr1), .rdata(rdata1)
  );

  assign hi        = half_r ? SET_CNT : HALF_CNT;
  assign lo        = half_r ? HALF_CNT : '0;
  assign i_inc     = i_r + CNT_W'(1);
  assign slot_free = !out_valid_r || pop;

  assign empty            = !out_valid_r;
  assign out_sorted_value = out_data_r;
  assign out_final_res    = out_final_r;

  always_comb begin
    priority if (a_r >= HALF_CNT) begin
      take_first = 1'b0;
    end else if (b_r >= SET_CNT) begin
      take_first = 1'b1;
    end else begin
      take_first = $signed(rdata0) < $signed(rdata1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    half_nxt      = half_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pick_nxt      = pick_r;
    ridx_nxt      = ridx_r;
    rv_nxt        = rv_r;
    best_nxt      = best_r;
    cur_nxt       = cur_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !pop;
    out_data_nxt  = out_data_r;
    out_final_nxt = out_final_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = q_head.req.idx;
    wdata         = q_head.req.value;
    re0           = 1'b0;
    re1           = 1'b0;
    raddr0        = i_r[ADDR_W-1:0];
    raddr1        = b_r[ADDR_W-1:0];
    emit          = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        if (q_head.valid) begin
          q_pop = 1'b1;
          we    = 1'b1;
          if (q_head.req.last) begin
            half_nxt  = 1'b0;
            i_nxt     = '0;
            state_nxt = ST_OUTER;
          end
        end
      end
      ST_OUTER: begin
        if (i_inc >= hi) begin
          if (!half_r) begin
            half_nxt = 1'b1;
            i_nxt    = HALF_CNT;
          end else begin
            a_nxt     = '0;
            b_nxt     = HALF_CNT;
            k_nxt     = '0;
            state_nxt = ST_MFETCH;
          end
        end else begin
          re0       = 1'b1;
          state_nxt = ST_CUR;
        end
      end
      ST_CUR: begin
        cur_nxt   = rdata0;
        best_nxt  = rdata0;
        pick_nxt  = i_r;
        j_nxt     = i_inc;
        rv_nxt    = 1'b0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (j_r < hi) begin
          re0      = 1'b1;
          raddr0   = j_r[ADDR_W-1:0];
          rv_nxt   = 1'b1;
          ridx_nxt = j_r;
          j_nxt    = j_r + CNT_W'(1);
        end else begin
          rv_nxt = 1'b0;
        end
        if (rv_r && ($signed(rdata0) < $signed(best_r))) begin
          best_nxt = rdata0;
          pick_nxt = ridx_r;
        end
        if (j_r >= hi && !rv_r) begin
          if (pick_r != i_r) begin
            state_nxt = ST_SWAP1;
          end else begin
            i_nxt     = i_inc;
            state_nxt = ST_OUTER;
          end
        end
      end
      ST_SWAP1: begin
        we        = 1'b1;
        waddr     = pick_r[ADDR_W-1:0];
        wdata     = cur_r;
        state_nxt = ST_SWAP2;
      end
      ST_SWAP2: begin
        we        = 1'b1;
        waddr     = i_r[ADDR_W-1:0];
        wdata     = best_r;
        i_nxt     = i_inc;
        state_nxt = ST_OUTER;
      end
      ST_MFETCH: begin
        re0       = (a_r < HALF_CNT);
        raddr0    = a_r[ADDR_W-1:0];
        re1       = (b_r < SET_CNT);
        state_nxt = ST_MEMIT;
      end
      ST_MEMIT: begin
        if (slot_free) begin
          emit          = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = take_first ? rdata0 : rdata1;
          out_final_nxt = (k_r == LAST_CNT);
          k_nxt         = k_r + CNT_W'(1);
          if (take_first) begin
            a_nxt = a_r + CNT_W'(1);
          end else begin
            b_nxt = b_r + CNT_W'(1);
          end
          state_nxt = (k_r == LAST_CNT) ? ST_LOAD : ST_MFETCH;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rv_r        <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    half_r      <= half_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    pick_r      <= pick_nxt;
    ridx_r      <= ridx_nxt;
    best_r      <= best_nxt;
    cur_r       <= cur_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    k_r         <= k_nxt;
    out_data_r  <= out_data_nxt;
    out_final_r <= out_final_nxt;
  end

  `TSM_ASSERT(a_pick_in_half, state_r == ST_SCAN |-> pick_r >= lo && pick_r < hi,
              "selected index outside current half")
  `TSM_ASSERT(a_final_to_load, emit && out_final_nxt |=> state_r == ST_LOAD,
              "merge did not return to loading after final result")
  `TSM_ASSERT(a_pop_only_load, q_pop |-> state_r == ST_LOAD,
              "request taken while sorting or merging")

endmodule

@@ design/two_half_sort_and_merge.sv @@
// Sorts sets of 16 signed 32-bit values and returns them in ascending order.
// Input channel: in_value is taken when push is high and full is low. Every
// 16th request closes a set; values are numbered by arrival within the set.
// Result channel: while empty is low, out_sorted_value holds the oldest
// result; it leaves when pop is high. out_final_res marks the last result of
// a set. Results of a set follow the order of a two-way merge of the two
// separately sorted halves, second half first on equal values.
// Requests pass through a two-entry queue; the store takes them only while loading.
// After the last request of a set the two halves are sorted in turn by
// selection sort on a single read port. The merge then reads both halves
// through a mirrored copy of the store and fetches both heads before it
// emits each result.
// While the receiver stalls, the result and the merge hold; the queue keeps
// taking requests until it fills, then full rises.
// Reset (rst_n low at a clock edge) empties the queue and result register
// and restarts set counting; stored values are not cleared.
module two_half_sort_and_merge
  import tsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [DATA_W-1:0] in_value,
  output logic              empty,
  input  logic              pop,
  output logic [DATA_W-1:0] out_sorted_value,
  output logic              out_final_res
);

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  req_t    q_req;
  q_head_t q_head;

  tsm_front u_front (
    .clk, .rst_n, .push, .full, .in_value, .q_full, .q_push, .q_req
  );

  tsm_queue u_queue (
    .clk, .rst_n, .q_push, .q_req, .q_full, .q_pop, .q_head
  );

  tsm_back u_back (
    .clk, .rst_n, .q_head, .q_pop, .empty, .pop, .out_sorted_value, .out_final_res
  );

endmodule
